### hw/rtl/weighted_quorum_table_defines.svh
// Assertion macros shared by the weighted quorum table RTL.
`ifndef WEIGHTED_QUORUM_TABLE_DEFINES_SVH
`define WEIGHTED_QUORUM_TABLE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off during reset
`define WQT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wqt assertion failed");
// Next-cycle implication, sampled on i_clk, off during reset
`define WQT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wqt assertion failed");
`else
`define WQT_ASSERT_IMP(lbl, ante, cons)
`define WQT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/wqt_pkg.sv
// Types and constants of the weighted quorum table.
package wqt_pkg;

    localparam int TABLE_SLOTS  = 16;
    localparam int ID_BITS      = 16;
    localparam int CMD_BITS     = 2;
    localparam int NODE_ID_BITS = 16;
    localparam int STATUS_BITS  = 2;
    localparam int WEIGHT_BITS  = 8;

    // Significant id bits held in the table
    localparam int KEY_BITS  = (ID_BITS < NODE_ID_BITS) ? ID_BITS : NODE_ID_BITS;
    localparam int SLOT_BITS = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int MEM_BITS  = KEY_BITS + WEIGHT_BITS;

    localparam logic [SLOT_BITS-1:0]   LAST_SLOT  = SLOT_BITS'(TABLE_SLOTS - 1);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = WEIGHT_BITS'(255);
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INC  = 2'd0,
        CMD_DEC  = 2'd1,
        CMD_ACC  = 2'd2,
        CMD_EVAL = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_DONE   = 2'd0,
        STAT_LIMIT  = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

endpackage

### hw/rtl/wqt_req_if.sv
// Request channel: command and node id with valid/ready handshake.
interface wqt_req_if;
    logic                              valid;
    logic                              ready;
    logic [wqt_pkg::CMD_BITS-1:0]      cmd;
    logic [wqt_pkg::NODE_ID_BITS-1:0]  node_id;

    modport source (output valid, output cmd, output node_id, input ready);
    modport sink   (input valid, input cmd, input node_id, output ready);
endinterface

### hw/rtl/wqt_rsp_if.sv
// Response channel: status, quorum flag and weights with valid/ready handshake.
interface wqt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [wqt_pkg::STATUS_BITS-1:0]  status;
    logic                             quorate;
    logic [wqt_pkg::WEIGHT_BITS-1:0]  sum_weight;
    logic [wqt_pkg::WEIGHT_BITS-1:0]  node_weight;
    logic [wqt_pkg::WEIGHT_BITS-1:0]  vote_weight;

    modport source (output valid, output status, output quorate, output sum_weight,
                    output node_weight, output vote_weight, input ready);
    modport sink   (input valid, input status, input quorate, input sum_weight,
                    input node_weight, input vote_weight, output ready);
endinterface

### hw/rtl/weighted_quorum_table.sv
// Weighted quorum table: voter ids and weights in a table memory, walked per command.
//
// Increment, decrement and acceptor commands each walk the voter table once through its
// one synchronous read port, one slot per cycle, then apply the update with at most one write
// and register the result. Evaluate needs no walk. A finished result sits in an output
// register, so the next request transfers while the previous result still waits; the
// update of that next request holds until the waiting result is taken. Ids and weights
// live in memory; the valid and acceptor mark bits are flip-flops cleared by reset, so
// no clearing pass is needed.
`include "weighted_quorum_table_defines.svh"

module weighted_quorum_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wqt_req_if.sink    i_req,
    wqt_rsp_if.source  o_rsp
);

    // Control state
    wqt_pkg::t_state                   r_state, n_state;
    logic [wqt_pkg::TABLE_SLOTS-1:0]   r_valid, n_valid;
    logic [wqt_pkg::TABLE_SLOTS-1:0]   r_marked, n_marked;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   r_wsum, n_wsum;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   r_vsum, n_vsum;
    logic                              r_out_valid;
    logic                              r_chk;
    logic                              r_hit;

    // Held request and walk state
    wqt_pkg::t_cmd                     r_cmd;
    logic [wqt_pkg::KEY_BITS-1:0]      r_id;
    logic [wqt_pkg::SLOT_BITS-1:0]     r_rd_idx;
    logic [wqt_pkg::SLOT_BITS-1:0]     r_chk_idx;
    logic [wqt_pkg::SLOT_BITS-1:0]     r_hit_idx;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   r_hit_w;

    // Table memory: {node id, weight}
    logic [wqt_pkg::MEM_BITS-1:0]      r_mem [wqt_pkg::TABLE_SLOTS];
    logic [wqt_pkg::MEM_BITS-1:0]      r_rd_data;
    logic                              mem_we;
    logic [wqt_pkg::SLOT_BITS-1:0]     mem_wr_idx;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   mem_wr_w;

    // Result register
    wqt_pkg::t_status                  r_status, res_status;
    logic                              r_quor, res_quor;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   r_total;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   r_nw, res_nw;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   r_acc, res_acc;

    logic                              req_fire;
    logic                              out_free;
    logic                              load;
    logic                              rd_match;
    logic                              free_found;
    logic [wqt_pkg::SLOT_BITS-1:0]     free_idx;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   w_inc;
    logic [wqt_pkg::WEIGHT_BITS-1:0]   w_dec;

    assign i_req.ready = (r_state == wqt_pkg::S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.quorate     = r_quor;
    assign o_rsp.sum_weight  = r_total;
    assign o_rsp.node_weight = r_nw;
    assign o_rsp.vote_weight = r_acc;

    // Compare the slot read last cycle against the held id
    assign rd_match = r_chk && r_valid[r_chk_idx] &&
                      (r_rd_data[wqt_pkg::MEM_BITS-1:wqt_pkg::WEIGHT_BITS] == r_id);

    assign w_inc = r_hit_w + wqt_pkg::WEIGHT_ONE;
    assign w_dec = r_hit_w - wqt_pkg::WEIGHT_ONE;

    // Find the lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = wqt_pkg::TABLE_SLOTS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_found = 1'b1;
                free_idx   = wqt_pkg::SLOT_BITS'(k);
            end
        end
    end

    // Next state, table update and result
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_marked   = r_marked;
        n_wsum     = r_wsum;
        n_vsum     = r_vsum;
        mem_we     = 1'b0;
        mem_wr_idx = r_hit_idx;
        mem_wr_w   = r_hit_w;
        res_status = wqt_pkg::STAT_DONE;
        res_quor   = 1'b0;
        res_nw     = '0;
        load       = 1'b0;

        unique case (r_state)
            wqt_pkg::S_IDLE: begin
                if (req_fire) begin
                    n_state = (wqt_pkg::t_cmd'(i_req.cmd) == wqt_pkg::CMD_EVAL) ?
                              wqt_pkg::S_APPLY : wqt_pkg::S_SCAN;
                end
            end
            wqt_pkg::S_SCAN: begin
                if (r_chk && (r_chk_idx == wqt_pkg::LAST_SLOT)) begin
                    n_state = wqt_pkg::S_APPLY;
                end
            end
            wqt_pkg::S_APPLY: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = wqt_pkg::S_IDLE;
                    unique case (r_cmd)
                        wqt_pkg::CMD_INC: begin
                            if (r_wsum == wqt_pkg::WEIGHT_MAX) begin
                                res_status = wqt_pkg::STAT_LIMIT;
                                res_nw     = r_hit ? r_hit_w : '0;
                            end else if (r_hit) begin
                                mem_we   = 1'b1;
                                mem_wr_w = w_inc;
                                n_wsum   = r_wsum + wqt_pkg::WEIGHT_ONE;
                                if (r_marked[r_hit_idx]) begin
                                    n_vsum = r_vsum + wqt_pkg::WEIGHT_ONE;
                                end
                                res_nw = w_inc;
                            end else if (free_found) begin
                                mem_we             = 1'b1;
                                mem_wr_idx         = free_idx;
                                mem_wr_w           = wqt_pkg::WEIGHT_ONE;
                                n_valid[free_idx]  = 1'b1;
                                n_marked[free_idx] = 1'b0;
                                n_wsum             = r_wsum + wqt_pkg::WEIGHT_ONE;
                                res_nw             = wqt_pkg::WEIGHT_ONE;
                            end else begin
                                res_status = wqt_pkg::STAT_FULL;
                            end
                        end
                        wqt_pkg::CMD_DEC: begin
                            if (r_wsum <= wqt_pkg::WEIGHT_ONE) begin
                                res_status = wqt_pkg::STAT_LIMIT;
                                res_nw     = r_hit ? r_hit_w : '0;
                            end else if (!r_hit) begin
                                res_status = wqt_pkg::STAT_ABSENT;
                            end else begin
                                if (r_marked[r_hit_idx]) begin
                                    n_vsum = r_vsum - wqt_pkg::WEIGHT_ONE;
                                end
                                n_wsum = r_wsum - wqt_pkg::WEIGHT_ONE;
                                if (r_hit_w <= wqt_pkg::WEIGHT_ONE) begin
                                    // Free the slot at its last unit of weight
                                    n_valid[r_hit_idx]  = 1'b0;
                                    n_marked[r_hit_idx] = 1'b0;
                                end else begin
                                    mem_we   = 1'b1;
                                    mem_wr_w = w_dec;
                                    res_nw   = w_dec;
                                end
                            end
                        end
                        wqt_pkg::CMD_ACC: begin
                            if (!r_hit) begin
                                res_status = wqt_pkg::STAT_ABSENT;
                            end else begin
                                if (!r_marked[r_hit_idx]) begin
                                    n_marked[r_hit_idx] = 1'b1;
                                    n_vsum              = r_vsum + r_hit_w;
                                end
                                res_nw = r_hit_w;
                            end
                        end
                        wqt_pkg::CMD_EVAL: begin
                            res_quor = (r_wsum != '0) &&
                                       ({1'b0, r_wsum} < {r_vsum, 1'b0});
                            n_marked = '0;
                            n_vsum   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = wqt_pkg::S_IDLE;
            end
        endcase

        res_acc = (r_cmd == wqt_pkg::CMD_EVAL) ? r_vsum : n_vsum;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wqt_pkg::S_IDLE;
            r_valid     <= '0;
            r_marked    <= '0;
            r_wsum      <= '0;
            r_vsum      <= '0;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_marked <= n_marked;
            r_wsum   <= n_wsum;
            r_vsum   <= n_vsum;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (req_fire) begin
                r_chk <= 1'b0;
                r_hit <= 1'b0;
            end else if (r_state == wqt_pkg::S_SCAN) begin
                r_chk <= 1'b1;
                if (rd_match) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // Capture the request, advance the walk, record the hit
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_cmd    <= wqt_pkg::t_cmd'(i_req.cmd);
            r_id     <= i_req.node_id[wqt_pkg::KEY_BITS-1:0];
            r_rd_idx <= '0;
        end else if ((r_state == wqt_pkg::S_SCAN) && (r_rd_idx != wqt_pkg::LAST_SLOT)) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_chk_idx <= r_rd_idx;
        if (rd_match) begin
            r_hit_idx <= r_chk_idx;
            r_hit_w   <= r_rd_data[wqt_pkg::WEIGHT_BITS-1:0];
        end
        if (load) begin
            r_status <= res_status;
            r_quor   <= res_quor;
            r_total  <= n_wsum;
            r_nw     <= res_nw;
            r_acc    <= res_acc;
        end
    end

    // Table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wr_idx] <= {r_id, mem_wr_w};
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // A marked acceptor is always a table member
    `WQT_ASSERT_IMP(a_mark_member, 1'b1, (r_marked & ~r_valid) == '0)
    // Any member carries weight, so the total cannot be zero
    `WQT_ASSERT_IMP(a_total_nonzero, (r_valid != '0), (r_wsum != '0))
    // Marked weight is part of the total
    `WQT_ASSERT_IMP(a_vote_le_total, 1'b1, (r_vsum <= r_wsum))
    // A request transfer starts work on it
    `WQT_ASSERT_NEXT(a_busy_after_xfer, req_fire, (r_state != wqt_pkg::S_IDLE))

endmodule

### verif/weighted_quorum_table_tb.sv
// Self-checking testbench for the weighted quorum table: directed and random commands.
`timescale 1ns / 100ps

module weighted_quorum_table_tb;

    typedef logic [wqt_pkg::NODE_ID_BITS-1:0] t_node_id;
    typedef logic [wqt_pkg::WEIGHT_BITS-1:0]  t_weight;

    typedef struct {
        wqt_pkg::t_status status;
        logic             quorate;
        t_weight          sum_weight;
        t_weight          node_weight;
        t_weight          vote_weight;
    } t_quorum_result;

    localparam t_node_id KEY_MASK     = t_node_id'((64'd1 << wqt_pkg::KEY_BITS) - 1);
    localparam int       CYCLE_LIMIT  = 400000;
    localparam int       DRAIN_CYCLES = 24;
    localparam int       POOL_SIZE    = 24;
    localparam int       PHASE_ITEMS  = 600;

    // Voter table mirror; computes the result of each command and holds the ones still due
    class quorum_ledger;
        t_node_id       voter_id[wqt_pkg::TABLE_SLOTS];
        int             voter_weight[wqt_pkg::TABLE_SLOTS];
        bit             voter_used[wqt_pkg::TABLE_SLOTS];
        bit             voter_marked[wqt_pkg::TABLE_SLOTS];
        int             weight_total;
        int             marked_total;
        t_quorum_result due_reports[$];
        int             errors;

        function new();
            for (int i = 0; i < wqt_pkg::TABLE_SLOTS; i++) begin
                voter_id[i]     = '0;
                voter_weight[i] = 0;
                voter_used[i]   = 1'b0;
                voter_marked[i] = 1'b0;
            end
            weight_total = 0;
            marked_total = 0;
            errors       = 0;
        endfunction

        function int find_voter(t_node_id key);
            for (int i = 0; i < wqt_pkg::TABLE_SLOTS; i++)
                if (voter_used[i] && voter_id[i] == key)
                    return i;
            return -1;
        endfunction

        function int lowest_free();
            for (int i = 0; i < wqt_pkg::TABLE_SLOTS; i++)
                if (!voter_used[i])
                    return i;
            return -1;
        endfunction

        // Pick the id of a random current member, or any id when the table is empty
        function t_node_id random_member();
            int members[$];
            for (int i = 0; i < wqt_pkg::TABLE_SLOTS; i++)
                if (voter_used[i])
                    members = {members, i};
            if (members.size() == 0)
                return t_node_id'($urandom);
            return voter_id[members[$urandom_range(0, members.size() - 1)]];
        endfunction

        // Apply one accepted command to the mirror and queue its result
        function void note_command(wqt_pkg::t_cmd cmd, t_node_id node_id);
            t_quorum_result want;
            t_node_id       key;
            int             s;
            key  = node_id & KEY_MASK;
            want = '{status: wqt_pkg::STAT_DONE, quorate: 1'b0, sum_weight: '0,
                     node_weight: '0, vote_weight: '0};
            s    = -1;
            case (cmd)
                wqt_pkg::CMD_INC: begin
                    s = find_voter(key);
                    if (weight_total == 255) begin
                        want.status = wqt_pkg::STAT_LIMIT;
                    end else if (s >= 0) begin
                        voter_weight[s]++;
                        weight_total++;
                        if (voter_marked[s])
                            marked_total++;
                    end else begin
                        s = lowest_free();
                        if (s < 0) begin
                            want.status = wqt_pkg::STAT_FULL;
                        end else begin
                            voter_id[s]     = key;
                            voter_weight[s] = 1;
                            voter_used[s]   = 1'b1;
                            voter_marked[s] = 1'b0;
                            weight_total++;
                        end
                    end
                end
                wqt_pkg::CMD_DEC: begin
                    s = find_voter(key);
                    if (weight_total <= 1) begin
                        want.status = wqt_pkg::STAT_LIMIT;
                    end else if (s < 0) begin
                        want.status = wqt_pkg::STAT_ABSENT;
                    end else begin
                        if (voter_marked[s])
                            marked_total--;
                        weight_total--;
                        // drop the voter once its weight runs out
                        if (voter_weight[s] <= 1) begin
                            voter_weight[s] = 0;
                            voter_used[s]   = 1'b0;
                            voter_marked[s] = 1'b0;
                            s = -1;
                        end else begin
                            voter_weight[s]--;
                        end
                    end
                end
                wqt_pkg::CMD_ACC: begin
                    s = find_voter(key);
                    if (s < 0) begin
                        want.status = wqt_pkg::STAT_ABSENT;
                    end else if (!voter_marked[s]) begin
                        voter_marked[s] = 1'b1;
                        marked_total += voter_weight[s];
                    end
                end
                default: ;
            endcase
            if (s >= 0 && cmd != wqt_pkg::CMD_EVAL)
                want.node_weight = t_weight'(voter_weight[s]);
            want.vote_weight = t_weight'(marked_total);
            // evaluate reports the majority, then clears every mark
            if (cmd == wqt_pkg::CMD_EVAL) begin
                want.quorate = (weight_total > 0) && (weight_total < 2 * marked_total);
                for (int i = 0; i < wqt_pkg::TABLE_SLOTS; i++)
                    voter_marked[i] = 1'b0;
                marked_total = 0;
            end
            want.sum_weight = t_weight'(weight_total);
            due_reports = {due_reports, want};
        endfunction

        // Compare one transferred result against the oldest one due
        function void check_result(t_quorum_result got);
            t_quorum_result want;
            if (due_reports.size() == 0) begin
                $error("result transferred with none due");
                errors++;
                return;
            end
            want = due_reports.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.quorate !== want.quorate) begin
                $error("quorate: expected %0d, got %0d", want.quorate, got.quorate);
                errors++;
            end
            if (got.sum_weight !== want.sum_weight) begin
                $error("sum_weight: expected %0d, got %0d",
                       want.sum_weight, got.sum_weight);
                errors++;
            end
            if (got.node_weight !== want.node_weight) begin
                $error("node_weight: expected %0d, got %0d",
                       want.node_weight, got.node_weight);
                errors++;
            end
            if (got.vote_weight !== want.vote_weight) begin
                $error("vote_weight: expected %0d, got %0d",
                       want.vote_weight, got.vote_weight);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    wqt_req_if req_if();
    wqt_rsp_if rsp_if();

    weighted_quorum_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    quorum_ledger ledger = new();

    int       send_idle_pct;
    int       recv_idle_pct;
    int       cycle_count;
    int       sent_count;
    bit       climbing;
    t_node_id id_pool[POOL_SIZE];

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[weighted_quorum_table] ERROR");
            $finish;
        end
    end

    // Take results, stalling at random
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready)
                ledger.check_result('{status: wqt_pkg::t_status'(rsp_if.status),
                                      quorate: rsp_if.quorate,
                                      sum_weight: rsp_if.sum_weight,
                                      node_weight: rsp_if.node_weight,
                                      vote_weight: rsp_if.vote_weight});
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Present one command, idling first at random, and hold it until the transfer
    task automatic send_command(wqt_pkg::t_cmd cmd, t_node_id node_id);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid   <= 1'b0;
            req_if.cmd     <= wqt_pkg::CMD_BITS'($urandom);
            req_if.node_id <= t_node_id'($urandom);
            @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.cmd     <= cmd;
        req_if.node_id <= node_id;
        do @(posedge i_clk); while (!req_if.ready);
        ledger.note_command(cmd, node_id);
        sent_count++;
    endtask

    function automatic t_node_id pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return ledger.random_member();
        if (r < 85)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        return t_node_id'($urandom);
    endfunction

    // Random traffic: weight climbs toward the limit, then drains to the floor, with ballots
    task automatic run_random(int count);
        int goal;
        int r;
        int votes;
        goal = sent_count + count;
        while (sent_count < goal) begin
            if (climbing && ledger.weight_total == 255 && $urandom_range(0, 9) == 0)
                climbing = 1'b0;
            if (!climbing && ledger.weight_total <= 1 && $urandom_range(0, 5) == 0)
                climbing = 1'b1;
            r = $urandom_range(0, 99);
            if (r >= 88) begin
                // ballot: mark a few acceptors, then evaluate
                votes = $urandom_range(0, 8);
                repeat (votes)
                    send_command(wqt_pkg::CMD_ACC, pick_id());
                send_command(wqt_pkg::CMD_EVAL, t_node_id'($urandom));
            end else if (r >= 80) begin
                send_command(wqt_pkg::CMD_ACC, pick_id());
            end else if ((climbing && r < 65) || (!climbing && r < 10)) begin
                send_command(wqt_pkg::CMD_INC, pick_id());
            end else begin
                send_command(wqt_pkg::CMD_DEC, pick_id());
            end
        end
    endtask

    // Short directed sequence over the corner cases
    task automatic run_directed();
        send_command(wqt_pkg::CMD_EVAL, 16'h0000);   // empty table is never quorate
        send_command(wqt_pkg::CMD_DEC,  16'h0000);   // decrement at the floor
        send_command(wqt_pkg::CMD_ACC,  16'h0005);   // acceptor not in the table
        send_command(wqt_pkg::CMD_INC,  16'h0000);
        send_command(wqt_pkg::CMD_INC,  16'hFFFF);
        send_command(wqt_pkg::CMD_INC,  16'hFFFF);
        send_command(wqt_pkg::CMD_DEC,  16'h1234);   // absent node
        send_command(wqt_pkg::CMD_ACC,  16'hFFFF);
        send_command(wqt_pkg::CMD_ACC,  16'hFFFF);   // repeated acceptor counts once
        send_command(wqt_pkg::CMD_INC,  16'hFFFF);   // marked weight follows the increment
        send_command(wqt_pkg::CMD_DEC,  16'hFFFF);   // and the decrement
        send_command(wqt_pkg::CMD_EVAL, 16'hFFFF);   // majority reached
        send_command(wqt_pkg::CMD_ACC,  16'h0000);
        send_command(wqt_pkg::CMD_EVAL, 16'h0000);   // minority only
        send_command(wqt_pkg::CMD_DEC,  16'h0000);   // weight one frees the slot
        send_command(wqt_pkg::CMD_INC,  16'h8000);   // reuses the lowest free slot
        send_command(wqt_pkg::CMD_ACC,  16'h8000);
        send_command(wqt_pkg::CMD_DEC,  16'h8000);   // removal of a marked member
        send_command(wqt_pkg::CMD_EVAL, 16'h5555);
        send_command(wqt_pkg::CMD_DEC,  16'hFFFF);
        send_command(wqt_pkg::CMD_DEC,  16'hFFFF);   // total at one
        send_command(wqt_pkg::CMD_INC,  16'hAAAA);
    endtask

    // Reset, stimulus in three idling phases, drain, verdict
    initial begin
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.cmd     = wqt_pkg::CMD_INC;
        req_if.node_id = '0;
        rsp_if.ready   = 1'b0;
        cycle_count    = 0;
        sent_count     = 0;
        climbing       = 1'b1;
        send_idle_pct  = 31;
        recv_idle_pct  = 68;
        id_pool[0] = 16'h0000;
        id_pool[1] = 16'hFFFF;
        id_pool[2] = 16'h8000;
        id_pool[3] = 16'h7FFF;
        id_pool[4] = 16'hAAAA;
        id_pool[5] = 16'h5555;
        for (int i = 6; i < POOL_SIZE; i++)
            id_pool[i] = t_node_id'($urandom);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random(PHASE_ITEMS);
        send_idle_pct = 68;
        recv_idle_pct = 31;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);

        req_if.valid <= 1'b0;
        while (ledger.due_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.errors == 0)
            $display("[weighted_quorum_table] OK");
        else
            $display("[weighted_quorum_table] ERROR");
        $finish;
    end

endmodule
